/* src/fqmm_pkg.sv */
package fqmm_pkg;

   // queue geometry
   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int OCC_W  = 5;
   localparam int WORD_W = 32;

   // request opcodes, anything else is search only
   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [1:0] opcode;
      word_type   push_value;
      word_type   search_key;
   } req_type;

   typedef struct packed {
      word_type         popped_value;
      logic             error;
      logic             found;
      logic [OCC_W-1:0] occupancy;
      word_type         largest;
      word_type         smallest;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic last;
   } status_type;

endpackage

/* src/fqmm_ctrl.sv */
module fqmm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  fqmm_pkg::status_type status,
   output fqmm_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.empty || status.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands and handshake
   assign cmd.load  = (state_ff == ST_IDLE) && start;
   assign cmd.step  = (state_ff == ST_SCAN) && !status.empty;
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

/* src/fqmm_datapath.sv */
module fqmm_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  fqmm_pkg::cmd_type    cmd,
   input  fqmm_pkg::req_type    req_payload,
   output fqmm_pkg::status_type status,
   output fqmm_pkg::rsp_type    rsp_payload
);

   fqmm_pkg::word_type             entries_ff [fqmm_pkg::DEPTH];
   fqmm_pkg::word_type             entries_in [fqmm_pkg::DEPTH];
   logic [fqmm_pkg::CNT_W-1:0]     count_ff;
   logic [fqmm_pkg::CNT_W-1:0]     count_in;
   logic [fqmm_pkg::IDX_W-1:0]     idx_ff;
   logic [fqmm_pkg::IDX_W-1:0]     idx_in;
   fqmm_pkg::word_type             key_ff;
   fqmm_pkg::word_type             key_in;
   fqmm_pkg::word_type             popped_ff;
   fqmm_pkg::word_type             popped_in;
   logic                           error_ff;
   logic                           error_in;
   logic                           found_ff;
   logic                           found_in;
   fqmm_pkg::word_type             max_ff;
   fqmm_pkg::word_type             max_in;
   fqmm_pkg::word_type             min_ff;
   fqmm_pkg::word_type             min_in;
   fqmm_pkg::word_type             sel;
   logic                           full;
   logic                           empty;

   assign full  = (count_ff == fqmm_pkg::CNT_W'(fqmm_pkg::DEPTH));
   assign empty = (count_ff == '0);
   assign sel   = entries_ff[idx_ff];

   // queue update on request, then one entry per cycle through the compare unit
   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      key_in     = key_ff;
      popped_in  = popped_ff;
      error_in   = error_ff;
      found_in   = found_ff;
      max_in     = max_ff;
      min_in     = min_ff;
      if (cmd.load) begin
         idx_in    = '0;
         key_in    = req_payload.search_key;
         popped_in = '0;
         error_in  = 1'b0;
         found_in  = 1'b0;
         max_in    = '0;
         min_in    = '0;
         case (req_payload.opcode)
            fqmm_pkg::OP_PUSH: begin
               if (full) begin
                  error_in = 1'b1;
               end else begin
                  entries_in[count_ff[fqmm_pkg::IDX_W-1:0]] = req_payload.push_value;
                  count_in = count_ff + fqmm_pkg::CNT_W'(1);
               end
            end
            fqmm_pkg::OP_POP: begin
               if (empty) begin
                  error_in = 1'b1;
               end else begin
                  popped_in = entries_ff[0];
                  for (int k = 0; k < fqmm_pkg::DEPTH - 1; k++) begin
                     entries_in[k] = entries_ff[k+1];
                  end
                  count_in = count_ff - fqmm_pkg::CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.step) begin
         found_in = found_ff | (sel == key_ff);
         if (idx_ff == '0) begin
            max_in = sel;
            min_in = sel;
         end else begin
            if (sel > max_ff) begin
               max_in = sel;
            end
            if (sel < min_ff) begin
               min_in = sel;
            end
         end
         idx_in = idx_ff + fqmm_pkg::IDX_W'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      key_ff     <= key_in;
      popped_ff  <= popped_in;
      error_ff   <= error_in;
      found_ff   <= found_in;
      max_ff     <= max_in;
      min_ff     <= min_in;
   end

   // status to controller
   assign status.empty = empty;
   assign status.last  = ((fqmm_pkg::CNT_W'(idx_ff) + fqmm_pkg::CNT_W'(1)) == count_ff);

   // result fields
   assign rsp_payload.popped_value = popped_ff;
   assign rsp_payload.error        = error_ff;
   assign rsp_payload.found        = found_ff;
   assign rsp_payload.occupancy    = fqmm_pkg::OCC_W'(count_ff);
   assign rsp_payload.largest      = max_ff;
   assign rsp_payload.smallest     = min_ff;

endmodule

/* src/fifo_queue_min_max_search.sv */
// Queue of signed 32-bit words with key search and max/min of the held words.
// A request is taken when start is high and busy is low; the queue is updated
// at that edge, then a single compare unit walks the held entries one per cycle
// (none when the queue is left empty), and the result is shown on rsp_payload
// for exactly one cycle with rsp_valid high. The receiver cannot stall it, so it
// must take the result in that cycle. Busy is high from the edge that takes a
// request until the result has been shown, and no new request is taken until it
// falls.
module fifo_queue_min_max_search (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fqmm_pkg::req_type req_payload,
   output logic              rsp_valid,
   output fqmm_pkg::rsp_type rsp_payload
);

   fqmm_pkg::cmd_type    cmd;
   fqmm_pkg::status_type status;

   fqmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   fqmm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

   // checks
   a_taken_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but busy not raised");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.occupancy <= fqmm_pkg::OCC_W'(fqmm_pkg::DEPTH)))
      else $error("occupancy beyond queue depth");

   a_error_no_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.error) |-> (rsp_payload.popped_value == '0))
      else $error("popped value on failed request");

endmodule
